// File: sv/assert_macros.svh
// Assertion macros used by the top level of the sorted set table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: sv/sust_pkg.sv
// Package: types, constants and command/status structs for the sorted set table.
package sust_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_READ   = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [VAL_W-1:0]  value;
    logic [7:0]               position;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]         entry_count;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic shift;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop_pending;
    logic last_shift;
  } dp_stat_t;

endpackage

// File: sv/sust_ctrl.sv
// Controller: sequences accept, execute, drop shifting and result hand-off.
module sust_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sust_pkg::dp_cmd_t  cmd,
  input  sust_pkg::dp_stat_t stat
);
  import sust_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Commands decoded from state
  always_comb begin
    req_stall    = (state != S_IDLE);
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.shift    = (state == S_SHIFT);
    cmd.out_load = (state == S_FINISH) && (!rsp_valid || !rsp_stall);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.drop_pending ? S_SHIFT : S_FINISH;
      end
      S_SHIFT: begin
        if (stat.last_shift) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (cmd.out_load) state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/sust_dp.sv
// Datapath: sorted entry cells, parallel compare, result and output registers.
module sust_dp (
  input  logic               clk,
  input  logic               rst,
  input  sust_pkg::dp_cmd_t  cmd,
  output sust_pkg::dp_stat_t stat,
  input  sust_pkg::item_t    req,
  output sust_pkg::result_t  rsp
);
  import sust_pkg::*;

  item_t                   item;
  logic signed [VAL_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        remain;
  status_t                 res_status;
  logic                    res_hit;
  logic signed [VAL_W-1:0] res_read;

  logic [CAPACITY-1:0]     lt;
  logic [CAPACITY-1:0]     eq;
  logic                    present;
  logic                    full;
  logic                    do_insert;
  logic                    read_ok;
  logic                    drop_bad;
  status_t                 status_next;
  logic                    hit_next;
  logic signed [VAL_W-1:0] read_next;

  // Every valid cell compares against the held value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count) && (entries[i] < item.value);
      eq[i] = (CNT_W'(i) < count) && (entries[i] == item.value);
    end
  end

  assign present   = |eq;
  assign full      = (count >= CNT_W'(CAPACITY));
  assign do_insert = cmd.exec && (item.mode == MODE_INSERT) && !present && !full;
  assign read_ok   = (item.position < count);
  assign drop_bad  = (item.position > count);

  assign stat.drop_pending = (item.mode == MODE_DROP) && (item.position != '0) && !drop_bad;
  assign stat.last_shift   = (remain == CNT_W'(1));

  // Result of the operation
  always_comb begin
    status_next = ST_OK;
    hit_next    = 1'b0;
    read_next   = '0;
    unique case (item.mode)
      MODE_INSERT: begin
        hit_next = present;
        if (!present && full) status_next = ST_FULL;
      end
      MODE_LOOKUP: begin
        hit_next = present;
      end
      MODE_READ: begin
        if (read_ok) read_next = entries[item.position[IDX_W-1:0]];
        else         status_next = ST_RANGE;
      end
      MODE_DROP: begin
        if (drop_bad) status_next = ST_RANGE;
      end
    endcase
  end

  // Entry cells: insert shifts up from the rank, drop shifts down by one
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    prev_lt;
    logic signed [VAL_W-1:0] below_val;
    logic signed [VAL_W-1:0] above_val;

    if (g == 0) begin : g_first
      assign prev_lt   = 1'b1;
      assign below_val = entries[g];
    end else begin : g_rest
      assign prev_lt   = lt[g-1];
      assign below_val = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign above_val = entries[g];
    end else begin : g_inner
      assign above_val = entries[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (g != 0 && !prev_lt) begin
          entries[g] <= below_val;
        end else if (prev_lt && !lt[g]) begin
          entries[g] <= item.value;
        end
      end else if (cmd.shift) begin
        entries[g] <= above_val;
      end
    end
  end

  // Count and drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      remain <= '0;
    end else begin
      if (do_insert) begin
        count <= count + CNT_W'(1);
      end else if (cmd.shift) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.exec) begin
        remain <= item.position;
      end else if (cmd.shift) begin
        remain <= remain - CNT_W'(1);
      end
    end
  end

  // Item, result and output payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.exec) begin
      res_status <= status_next;
      res_hit    <= hit_next;
      res_read   <= read_next;
    end
    if (cmd.out_load) begin
      rsp.status      <= res_status;
      rsp.hit         <= res_hit;
      rsp.read_value  <= res_read;
      rsp.entry_count <= count;
    end
  end

endmodule

// File: sv/sorted_unique_set_table.sv
// Top level of the sorted set table: controller, datapath and assertions.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  sust_pkg::item_t
//   rsp      out        rsp_valid / rsp_stall  sust_pkg::result_t
//
// Insert, lookup and read go from the transfer through the execute and finish states, and
// the output register loads in the finish state; no new item is taken until that state is left.
// Drop of n entries adds a shift state doing one cell-wide shift per dropped entry.
// A finished result waits in the output register while the next item is taken.
// Reset clears the entry count and control; entry cells are not cleared.
// A stalled result holds its payload; a new result waits until it is taken.
module sorted_unique_set_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sust_pkg::item_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sust_pkg::result_t rsp
);
  import sust_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sust_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  sust_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

  // Checks
  `ASSERT_ALWAYS(a_cmd_onehot, clk, rst, $onehot0({cmd.load, cmd.exec, cmd.shift, cmd.out_load}))
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, req_valid && !req_stall, req_stall)
  `ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.out_load, !(rsp_valid && rsp_stall))
  `ASSERT_IMPLY(a_count_bound, clk, rst, rsp_valid, rsp.entry_count <= CNT_W'(CAPACITY))

endmodule

// File: bench/tb_sorted_unique_set_table.sv
// Self-checking testbench for the sorted unique set table: directed and random set operations.
module tb_sorted_unique_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  import sust_pkg::*;

  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 3 + CAPACITY + 8;
  localparam int MAX_PRINTED  = 40;
  localparam int VAL_MIN      = 32'sh8000_0000;
  localparam int VAL_MAX      = 32'sh7fff_ffff;

  // Shadow copy of the set plus the results it predicts, oldest first
  class set_table_scoreboard;
    int          entries[CAPACITY];
    int unsigned count;
    result_t     pending_results[$];
    int          errors;

    task report(string msg);
      if (errors < MAX_PRINTED) $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one operation to the shadow set and return the result it gives
    function result_t apply_op(item_t it);
      result_t     r;
      int          v;
      int unsigned pos;
      int unsigned rank;
      r        = '0;
      r.status = ST_OK;
      v        = it.value;
      pos      = it.position;
      case (it.mode)
        MODE_INSERT, MODE_LOOKUP: begin
          // rank = number of entries strictly below the value
          rank = 0;
          for (int i = 0; i < count; i++)
            if (entries[i] < v) rank++;
          if (rank < count && entries[rank] == v) begin
            r.hit = 1'b1;
          end else if (it.mode == MODE_INSERT) begin
            if (count >= CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              for (int i = count; i > rank; i--) entries[i] = entries[i-1];
              entries[rank] = v;
              count++;
            end
          end
        end
        MODE_READ: begin
          if (pos < count) r.read_value = entries[pos];
          else r.status = ST_RANGE;
        end
        default: begin
          // drop the pos smallest entries; too many leaves the set alone
          if (pos > count) begin
            r.status = ST_RANGE;
          end else if (pos > 0) begin
            for (int i = 0; i + pos < count; i++) entries[i] = entries[i+pos];
            count -= pos;
          end
        end
      endcase
      r.entry_count = CNT_W'(count);
      return r;
    endfunction

    function void note_request(item_t it);
      pending_results = {pending_results, apply_op(it)};
    endfunction

    task check_response(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.hit !== want.hit)
          report($sformatf("hit %b, expected %b", got.hit, want.hit));
        if (got.read_value !== want.read_value)
          report($sformatf("read_value %0d, expected %0d", got.read_value, want.read_value));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                           want.entry_count));
      end
    endtask
  endclass

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_stall;
  item_t   req       = '0;
  logic    rsp_valid;
  logic    rsp_stall = 1'b0;
  result_t rsp;

  set_table_scoreboard sb = new;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent        = 0;

  always #5 clk = ~clk;

  sorted_unique_set_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_unique_set_table test failed");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next stall from the current phase
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    case ((cycle_count / 300) % 4)
      0:       rsp_stall <= 1'b0;
      1:       rsp_stall <= ($urandom_range(0, 9) < 3);
      2:       rsp_stall <= ($urandom_range(0, 9) < 7);
      default: rsp_stall <= (cycle_count % 3 == 0);
    endcase
  end

  // One request transfer; the sender idles between bursts of random length
  task automatic send_item(mode_t m, int v, int p);
    item_t it;
    it.mode     = m;
    it.value    = v;
    it.position = p[7:0];
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(it);
    burst_left--;
    sent++;
  endtask

  // Hold off until every outstanding result has been taken
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Values: fresh random, already stored, near zero, or the extremes
  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return (sb.count > 0) ? sb.entries[$urandom_range(0, sb.count - 1)] : $urandom;
    if (r == 7) return int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Insert until full, then a few more to hit the full-table case
  task automatic fill_table();
    while (sb.count < CAPACITY) send_item(MODE_INSERT, pick_value(), $urandom);
    repeat ($urandom_range(1, 3)) send_item(MODE_INSERT, pick_value(), $urandom);
  endtask

  // Read every index plus one past the end, interleaved with lookups
  task automatic sweep_table();
    int n;
    n = sb.count;
    for (int i = 0; i <= n; i++) begin
      send_item(MODE_READ, $urandom, i);
      send_item(MODE_LOOKUP, pick_value(), $urandom);
    end
  endtask

  task automatic drain_table();
    while (sb.count > 0) send_item(MODE_DROP, $urandom, $urandom_range(1, sb.count));
  endtask

  // Mixed operations, weighted toward insert so the set stays populated
  task automatic mixed_ops(int n);
    int r;
    int q;
    repeat (n) begin
      r = $urandom_range(0, 19);
      q = $urandom_range(0, 9);
      if (r < 9) begin
        send_item(MODE_INSERT, pick_value(), $urandom);
      end else if (r < 13) begin
        send_item(MODE_LOOKUP, pick_value(), $urandom);
      end else if (r < 17) begin
        send_item(MODE_READ, $urandom, (q < 7) ? $urandom_range(0, sb.count) : $urandom);
      end else begin
        if (q < 6) send_item(MODE_DROP, $urandom, $urandom_range(0, 3));
        else if (q < 9) send_item(MODE_DROP, $urandom, $urandom_range(0, sb.count + 1));
        else send_item(MODE_DROP, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, duplicates, misses, range errors, drop edge cases
    send_item(MODE_INSERT, 0, 0);
    send_item(MODE_INSERT, VAL_MAX, 255);
    send_item(MODE_INSERT, VAL_MIN, 0);
    send_item(MODE_INSERT, -1, 0);
    send_item(MODE_INSERT, 1, 0);
    send_item(MODE_INSERT, VAL_MAX, 0);      // duplicate
    send_item(MODE_LOOKUP, VAL_MIN, 0);
    send_item(MODE_LOOKUP, 5, 0);            // miss
    send_item(MODE_READ, 0, 0);
    send_item(MODE_READ, 0, 4);
    send_item(MODE_READ, 0, 5);              // one past the end
    send_item(MODE_READ, VAL_MIN, 255);
    send_item(MODE_DROP, 0, 0);              // drop nothing
    send_item(MODE_DROP, 0, 6);              // one more than held
    send_item(MODE_DROP, -1, 255);
    send_item(MODE_DROP, 0, 2);
    send_item(MODE_READ, 0, 0);
    send_item(MODE_DROP, 0, 3);              // empties the set
    send_item(MODE_READ, 0, 0);
    send_item(MODE_LOOKUP, 0, 0);
    send_item(MODE_DROP, 0, 1);              // drop from empty
    wait_idle();

    // Random scenarios
    fill_table();
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1:    fill_table();
        2:       sweep_table();
        3:       drain_table();
        default: mixed_ops($urandom_range(10, 40));
      endcase
      if ($urandom_range(0, 7) == 0) wait_idle();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorted_unique_set_table test passed");
    end else begin
      $display("sorted_unique_set_table test failed");
    end
    $finish;
  end

endmodule
